>>> hw/rtl/hid_keyboard_report_to_key_events_macros.svh
// Assertion macros used by the keyboard report back end.
// Each assertion runs on the rising edge of clk_i and is switched off while rst_ni is low.
// Under SYNTHESIS the macros expand to nothing.
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`ifndef SYNTHESIS
`define HKRE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HKRE_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HKRE_ASSERT(name, prop, msg)
`define HKRE_ASSERT_NEVER(name, cond, msg)
`endif
`endif

>>> hw/rtl/hkre_pkg.sv
`timescale 1ns / 1ps

package hkre_pkg;

  localparam logic [7:0] USAGE_BACKSPACE = 8'h2A;
  localparam logic [7:0] USAGE_CAPS_LOCK = 8'h39;
  localparam logic [7:0] USAGE_NUM_LOCK  = 8'h53;
  localparam logic [4:0] USAGE_MOD_BASE  = 5'b11100;  // modifier usages are 0xE0..0xE7

  localparam int ADB_DELETE   = 14;
  localparam int ADB_CAPS     = 13;
  localparam int ADB_CONTROL  = 11;
  localparam int ADB_SHIFT    = 10;
  localparam int ADB_OPTION   = 9;
  localparam int ADB_COMMAND  = 8;
  localparam int ADB_NUM      = 7;
  localparam int ADB_CAPS_LED = 1;
  localparam int ADB_NUM_LED  = 0;

  // Modifier bit that is reported at a given place of the event order:
  // LCtrl, RCtrl, LGUI, RGUI, LAlt, RAlt, LShift, RShift.
  function automatic logic [2:0] mod_bit(input int unsigned pos);
    logic [2:0] b;
    case (pos)
      0: b = 3'd0;
      1: b = 3'd4;
      2: b = 3'd3;
      3: b = 3'd7;
      4: b = 3'd2;
      5: b = 3'd6;
      6: b = 3'd1;
      7: b = 3'd5;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

  // Layout of one queued report, lowest bits first:
  // modifier byte, previous keys, current keys, event mask (8 modifier edges,
  // n releases, n presses), press directions, ADB word, LED bits.
  function automatic int ent_off_prev(input int n);
    return 8;
  endfunction
  function automatic int ent_off_cur(input int n);
    return 8 + 8 * n;
  endfunction
  function automatic int ent_off_mask(input int n);
    return 8 + 16 * n;
  endfunction
  function automatic int ent_off_down(input int n);
    return 16 + 18 * n;
  endfunction
  function automatic int ent_off_adb(input int n);
    return 16 + 19 * n;
  endfunction
  function automatic int ent_off_led(input int n);
    return 32 + 19 * n;
  endfunction
  function automatic int ent_width(input int n);
    return 34 + 19 * n;
  endfunction

endpackage

>>> hw/rtl/hkre_front.sv
`timescale 1ns / 1ps

module hkre_front import hkre_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [8*(KEY_SLOTS+1)-1:0]        in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ent_width(KEY_SLOTS)-1:0]   out_entry_o
);

  localparam int N  = KEY_SLOTS;

  logic [7:0]     held_q;
  logic [8*N-1:0] prev_q;
  logic           caps_q, caps_d;
  logic           num_q, num_d;
  logic           del_q, del_d;

  logic [7:0]     mods;
  logic [8*N-1:0] cur;
  logic [7:0]     mod_ev;
  logic [N-1:0]   rel, prs, down;
  logic [15:0]    word;
  logic           accept;

  assign mods   = in_data_i[7:0];
  assign cur    = in_data_i[8*N+7:8];
  assign accept = in_valid_i && out_ready_i;

  assign in_ready_o  = out_ready_i;
  assign out_valid_o = in_valid_i;

  // The whole report is classified in the accepting cycle; the state moves with it.
  always_comb begin
    logic hit;
    logic bs_set;
    logic bs_clr;
    logic caps_run;
    logic num_run;
    rel = '0;
    prs = '0;
    down = '0;
    bs_set = 1'b0;
    bs_clr = 1'b0;
    caps_run = caps_q;
    num_run = num_q;
    for (int p = 0; p < 8; p++) begin
      mod_ev[p] = mods[mod_bit(p)] ^ held_q[mod_bit(p)];
    end
    for (int i = 0; i < N; i++) begin
      hit = 1'b0;
      for (int j = 0; j < N; j++) begin
        if (cur[8*j+:8] == prev_q[8*i+:8]) begin
          hit = 1'b1;
        end
      end
      if (prev_q[8*i+:8] != 8'd0 && !hit) begin
        rel[i] = (prev_q[8*i+:8] != USAGE_CAPS_LOCK);
        if (prev_q[8*i+:8] == USAGE_BACKSPACE) begin
          bs_clr = 1'b1;
        end
      end
    end
    for (int j = 0; j < N; j++) begin
      hit = 1'b0;
      for (int i = 0; i < N; i++) begin
        if (prev_q[8*i+:8] == cur[8*j+:8]) begin
          hit = 1'b1;
        end
      end
      if (cur[8*j+:8] == USAGE_BACKSPACE) begin
        bs_set = 1'b1;
      end
      prs[j] = (cur[8*j+:8] != 8'd0) && !hit;
      down[j] = 1'b1;
      if (prs[j] && cur[8*j+:8] == USAGE_CAPS_LOCK) begin
        caps_run = !caps_run;
        down[j] = caps_run;
      end
      if (prs[j] && cur[8*j+:8] == USAGE_NUM_LOCK) begin
        num_run = !num_run;
      end
    end
    caps_d = caps_run;
    num_d = num_run;
    // A held Backspace wins; a released one clears the flag.
    if (bs_set) begin
      del_d = 1'b1;
    end else if (bs_clr) begin
      del_d = 1'b0;
    end else begin
      del_d = del_q;
    end
    word = '0;
    word[ADB_DELETE]   = del_d;
    word[ADB_CAPS]     = caps_d;
    word[ADB_CONTROL]  = mods[0] | mods[4];
    word[ADB_SHIFT]    = mods[1] | mods[5];
    word[ADB_OPTION]   = mods[2] | mods[6];
    word[ADB_COMMAND]  = mods[3] | mods[7];
    word[ADB_NUM]      = num_d;
    word[ADB_CAPS_LED] = caps_d;
    word[ADB_NUM_LED]  = num_d;
  end

  always_comb begin
    out_entry_o = '0;
    out_entry_o[7:0]                          = mods;
    out_entry_o[ent_off_prev(N)+:8*N]         = prev_q;
    out_entry_o[ent_off_cur(N)+:8*N]          = cur;
    out_entry_o[ent_off_mask(N)+:8+2*N]       = {prs, rel, mod_ev};
    out_entry_o[ent_off_down(N)+:N]           = down;
    out_entry_o[ent_off_adb(N)+:16]           = ~word;
    out_entry_o[ent_off_led(N)+:2]            = {caps_d, num_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      prev_q <= '0;
      caps_q <= 1'b0;
      num_q  <= 1'b0;
      del_q  <= 1'b0;
    end else if (accept) begin
      held_q <= mods;
      prev_q <= cur;
      caps_q <= caps_d;
      num_q  <= num_d;
      del_q  <= del_d;
    end
  end

endmodule

>>> hw/rtl/hkre_queue.sv
`timescale 1ns / 1ps

module hkre_queue import hkre_pkg::*; #(
  parameter int Width = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/hkre_back.sv
`timescale 1ns / 1ps
`include "hid_keyboard_report_to_key_events_macros.svh"

module hkre_back import hkre_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ent_width(KEY_SLOTS)-1:0]   in_entry_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_event_o,
  output logic                              out_down_o,
  output logic [7:0]                        out_code_o,
  output logic [15:0]                       out_adb_o,
  output logic [1:0]                        out_led_o,
  output logic                              out_last_o
);

  localparam int N = KEY_SLOTS;
  localparam int M = 9 + 2 * N;  // event slots plus the closing result

  logic           work_valid_q;
  logic [M-1:0]   mask_q;
  logic [7:0]     mods_q;
  logic [8*N-1:0] prev_q, cur_q;
  logic [N-1:0]   down_q;
  logic [15:0]    adb_q;
  logic [1:0]     led_q;

  logic           m_valid_q, m_event_q, m_down_q, m_last_q;
  logic [7:0]     m_code_q;
  logic [15:0]    m_adb_q;
  logic [1:0]     m_led_q;

  logic [M-1:0]   sel;
  logic [7:0]     code;
  logic           dn;
  logic           closing, out_free, step, finish, load;

  // Lowest pending slot goes out next.
  always_comb begin
    sel  = mask_q & (~mask_q + {{(M-1){1'b0}}, 1'b1});
    code = '0;
    dn   = 1'b0;
    for (int p = 0; p < 8; p++) begin
      if (sel[p]) begin
        code = code | {USAGE_MOD_BASE, mod_bit(p)};
        dn   = dn | mods_q[mod_bit(p)];
      end
    end
    for (int i = 0; i < N; i++) begin
      if (sel[8+i]) begin
        code = code | prev_q[8*i+:8];
      end
      if (sel[8+N+i]) begin
        code = code | cur_q[8*i+:8];
        dn   = dn | down_q[i];
      end
    end
  end

  assign closing    = sel[M-1];
  assign out_free   = !m_valid_q || out_ready_i;
  assign step       = work_valid_q && out_free;
  assign finish     = step && closing;
  assign in_ready_o = !work_valid_q || finish;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      mask_q       <= '0;
    end else if (load) begin
      work_valid_q <= 1'b1;
      mask_q       <= {1'b1, in_entry_i[ent_off_mask(N)+:8+2*N]};
    end else if (finish) begin
      work_valid_q <= 1'b0;
      mask_q       <= '0;
    end else if (step) begin
      mask_q <= mask_q & ~sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mods_q <= in_entry_i[7:0];
      prev_q <= in_entry_i[ent_off_prev(N)+:8*N];
      cur_q  <= in_entry_i[ent_off_cur(N)+:8*N];
      down_q <= in_entry_i[ent_off_down(N)+:N];
      adb_q  <= in_entry_i[ent_off_adb(N)+:16];
      led_q  <= in_entry_i[ent_off_led(N)+:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (step) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      m_event_q <= !closing;
      m_down_q  <= closing ? 1'b0 : dn;
      m_code_q  <= closing ? 8'd0 : code;
      m_adb_q   <= closing ? adb_q : 16'd0;
      m_led_q   <= closing ? led_q : 2'd0;
      m_last_q  <= closing;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_event_o = m_event_q;
  assign out_down_o  = m_down_q;
  assign out_code_o  = m_code_q;
  assign out_adb_o   = m_adb_q;
  assign out_led_o   = m_led_q;
  assign out_last_o  = m_last_q;

  `HKRE_ASSERT(a_closing_pending, work_valid_q |-> mask_q[M-1], "closing slot lost")
  `HKRE_ASSERT(a_step_fills_output, step |=> m_valid_q, "emitted result not shown")
  `HKRE_ASSERT_NEVER(a_last_on_event, m_valid_q && m_event_q && m_last_q, "event marked last")

endmodule

>>> hw/rtl/hid_keyboard_report_to_key_events.sv
`timescale 1ns / 1ps
// The first result of a report passes through the queue, the back end's work register and its output register.
// Throughput: one result per cycle unless m_axis_tready stalls the output; a report gives
// one result per event plus the closing status, 1 to 2*KEY_SLOTS+9 results in all.
// Reset: rst_ni clears all key, modifier and lock state and empties the queue and output.

module hid_keyboard_report_to_key_events import hkre_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // From bit 0: modifier_bits, key_slot_0 .. key_slot_(KEY_SLOTS-1), 8 bits each.
  input  logic [8*(KEY_SLOTS+1)-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // From bit 0: key_down (1), event_code (8), adb_reg2 (16), led_bits (2), zero fill (5).
  output logic [31:0]                  m_axis_tdata,
  // has_event (1).
  output logic                         m_axis_tuser,
  // last (1): set on the closing status result of a report.
  output logic                         m_axis_tlast
);

  // The front end compares each report with the stored one as it arrives and
  // updates the key, modifier and lock state in that same cycle. It hands a
  // classified report, with one pending bit per possible event, to a
  // two-entry queue. The back end walks the pending bits from the lowest up,
  // one result per cycle while the output is not stalled, into an output
  // register, and ends every report with the status result. Either side can
  // stall without holding up the other until the queue fills.

  localparam int EW = ent_width(KEY_SLOTS);

  logic          f_valid, f_ready;
  logic [EW-1:0] f_entry;
  logic          q_valid, q_ready;
  logic [EW-1:0] q_entry;
  logic          b_down;
  logic [7:0]    b_code;
  logic [15:0]   b_adb;
  logic [1:0]    b_led;

  hkre_front #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_entry_o (f_entry)
  );

  hkre_queue #(
    .Width(EW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_entry),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_entry)
  );

  hkre_back #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_entry_i  (q_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_event_o (m_axis_tuser),
    .out_down_o  (b_down),
    .out_code_o  (b_code),
    .out_adb_o   (b_adb),
    .out_led_o   (b_led),
    .out_last_o  (m_axis_tlast)
  );

  // Result fields packed from bit 0 and padded with zeros to four bytes.
  assign m_axis_tdata = {5'd0, b_led, b_adb, b_code, b_down};

endmodule
